### src/gls_pkg.sv
// Shared constants for the grid line-of-sight block.
`default_nettype none

package gls_pkg;

    localparam int X_W           = 10;
    localparam int Y_W           = 9;
    localparam int COORD_W       = 10;
    localparam int GRID_W_DEF    = 1024;
    localparam int GRID_H_DEF    = 512;
    localparam int FRAC_BITS_DEF = 16;
    localparam int WORD_W        = 64;
    localparam int WORD_BW       = 6;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

endpackage

`default_nettype wire

### src/gls_map_ram.sv
// Obstacle map storage: one write port, one read port with registered read data.
`default_nettype none

module gls_map_ram #(
    parameter int DEPTH  = 8192,
    parameter int ADDR_W = 13,
    parameter int DATA_W = 64
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### src/gls_div.sv
// Radix-2 restoring divider for the minor-axis step: (num << FRAC_BITS) / den, num <= den.
`default_nettype none

module gls_div #(
    parameter int FRAC_BITS = 16,
    parameter int LEN_W     = 10
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic [LEN_W-1:0]     num,
    input  wire logic [LEN_W-1:0]     den,
    output logic                      done,
    output logic      [FRAC_BITS:0]   quot
);

    localparam int CNT_W = $clog2(FRAC_BITS + 1);

    logic               busy_reg;
    logic               done_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [LEN_W-1:0]   den_reg;
    logic [LEN_W-1:0]   rem_reg;
    logic [FRAC_BITS:0] quot_reg;
    logic [LEN_W:0]     rem_shift;
    logic               q_bit;
    logic [LEN_W:0]     rem_sub;

    always_comb
    begin
        rem_shift = {rem_reg, 1'b0};
        q_bit     = (rem_shift >= {1'b0, den_reg});
        rem_sub   = rem_shift - {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            den_reg  <= '0;
            rem_reg  <= '0;
            quot_reg <= '0;
        end
        else
        begin
            done_reg <= !start && busy_reg && (cnt_reg == CNT_W'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(FRAC_BITS);
                den_reg  <= den;
                if (num == den)
                begin
                    rem_reg  <= '0;
                    quot_reg <= (FRAC_BITS + 1)'(1);
                end
                else
                begin
                    rem_reg  <= num;
                    quot_reg <= '0;
                end
            end
            else if (busy_reg)
            begin
                rem_reg  <= q_bit ? rem_sub[LEN_W-1:0] : rem_shift[LEN_W-1:0];
                quot_reg <= {quot_reg[FRAC_BITS-1:0], q_bit};
                cnt_reg  <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

`default_nettype wire

### src/grid_line_of_sight.sv
// Top level: obstacle map with cell writes and DDA line-of-sight queries.
`default_nettype none

// One obstacle bit per cell, kept in a single-port-read, single-port-write RAM of
// 64-bit words. After reset the block sweeps the RAM to clear it, one word a cycle,
// with in_ready low. A write word is a read, then a modify and write back. A query
// runs through a setup state, the bit-serial divider for the minor step, one RAM
// read per visited cell along the major axis, the pipeline drain and the load of
// the output register; the next word is accepted in the cycle after that load.
// Identical endpoints skip the divider and the walk. The next word is accepted
// while a finished result still waits on the output register.

module grid_line_of_sight #(
    parameter int GRID_W    = gls_pkg::GRID_W_DEF,
    parameter int GRID_H    = gls_pkg::GRID_H_DEF,
    parameter int FRAC_BITS = gls_pkg::FRAC_BITS_DEF
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic                    action,
    input  wire logic [gls_pkg::X_W-1:0] start_x,
    input  wire logic [gls_pkg::Y_W-1:0] start_y,
    input  wire logic [gls_pkg::X_W-1:0] end_x,
    input  wire logic [gls_pkg::Y_W-1:0] end_y,
    input  wire logic                    blocked,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic                         clear_path
);

    import gls_pkg::*;

    localparam int COLS   = (GRID_W < (1 << X_W)) ? GRID_W : (1 << X_W);
    localparam int ROWS   = (GRID_H < (1 << Y_W)) ? GRID_H : (1 << Y_W);
    localparam int CELLS  = COLS * ROWS;
    localparam int CELL_W = $clog2(CELLS);
    localparam int ADDR_W = CELL_W - WORD_BW;
    localparam int DEPTH  = (CELLS + WORD_W - 1) / WORD_W;
    localparam int ACC_W  = COORD_W + FRAC_BITS;

    typedef enum logic [2:0] {
        ST_CLR,
        ST_IDLE,
        ST_WR_RD,
        ST_WR_WB,
        ST_SETUP,
        ST_DIV,
        ST_WALK,
        ST_DONE
    } state_t;

    state_t               state_reg;
    logic [ADDR_W-1:0]    clr_cnt_reg;
    logic                 blocked_reg;
    logic [X_W-1:0]       sx_reg;
    logic [Y_W-1:0]       sy_reg;
    logic [X_W-1:0]       ex_reg;
    logic [Y_W-1:0]       ey_reg;
    logic [X_W-1:0]       cx_reg;
    logic [Y_W-1:0]       cy_reg;
    logic                 cv_reg;
    logic                 chk_reg;
    logic [WORD_BW-1:0]   bit_sel_reg;
    logic                 hit_reg;
    logic                 x_major_reg;
    logic                 maj_up_reg;
    logic                 min_up_reg;
    logic [COORD_W-1:0]   maj_pos_reg;
    logic [ACC_W-1:0]     acc_reg;
    logic [FRAC_BITS:0]   inc_reg;
    logic [COORD_W-1:0]   step_cnt_reg;
    logic                 out_valid_reg;
    logic                 clear_path_reg;

    // setup arithmetic
    logic [X_W-1:0]       adx;
    logic [Y_W-1:0]       ady;
    logic                 x_major;
    logic [COORD_W-1:0]   maj_len;
    logic [COORD_W-1:0]   min_len;
    logic                 zero_len;

    // walk step
    logic [COORD_W-1:0]   maj_next;
    logic [ACC_W-1:0]     acc_next;
    logic [COORD_W-1:0]   min_idx;
    logic [X_W-1:0]       cx_next;
    logic [Y_W-1:0]       cy_next;

    // addressing
    logic                 in_grid;
    logic [CELL_W-1:0]    cell_idx;
    logic [ADDR_W-1:0]    word_addr;

    // divider and RAM
    logic                 div_start;
    logic                 div_done;
    logic [FRAC_BITS:0]   div_quot;
    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_waddr;
    logic [WORD_W-1:0]    ram_wdata;
    logic                 ram_re;
    logic [WORD_W-1:0]    ram_rdata;

    always_comb
    begin
        adx      = (ex_reg >= sx_reg) ? ex_reg - sx_reg : sx_reg - ex_reg;
        ady      = (ey_reg >= sy_reg) ? ey_reg - sy_reg : sy_reg - ey_reg;
        x_major  = (COORD_W'(ady) <= COORD_W'(adx));
        maj_len  = x_major ? COORD_W'(adx) : COORD_W'(ady);
        min_len  = x_major ? COORD_W'(ady) : COORD_W'(adx);
        zero_len = (adx == '0) && (ady == '0);
    end

    always_comb
    begin
        maj_next = maj_up_reg ? maj_pos_reg + COORD_W'(1) : maj_pos_reg - COORD_W'(1);
        acc_next = min_up_reg ? acc_reg + ACC_W'(inc_reg) : acc_reg - ACC_W'(inc_reg);
        min_idx  = acc_next[FRAC_BITS +: COORD_W];
        if (step_cnt_reg == COORD_W'(1))
        begin
            cx_next = ex_reg;
            cy_next = ey_reg;
        end
        else if (x_major_reg)
        begin
            cx_next = maj_next[X_W-1:0];
            cy_next = min_idx[Y_W-1:0];
        end
        else
        begin
            cx_next = min_idx[X_W-1:0];
            cy_next = maj_next[Y_W-1:0];
        end
    end

    always_comb
    begin
        in_grid   = (32'(cx_reg) < COLS) && (32'(cy_reg) < ROWS);
        cell_idx  = CELL_W'(CELL_W'(cy_reg) * CELL_W'(COLS)) + CELL_W'(cx_reg);
        word_addr = cell_idx[CELL_W-1:WORD_BW];
    end

    always_comb
    begin
        div_start = (state_reg == ST_SETUP) && !zero_len;
        ram_re    = cv_reg || (state_reg == ST_WR_RD);
        ram_we    = (state_reg == ST_CLR) || (state_reg == ST_WR_WB);
        ram_waddr = (state_reg == ST_CLR) ? clr_cnt_reg : word_addr;
        ram_wdata = '0;
        if (state_reg == ST_WR_WB)
        begin
            ram_wdata              = ram_rdata;
            ram_wdata[bit_sel_reg] = blocked_reg;
        end
    end

    gls_div #(
        .FRAC_BITS (FRAC_BITS),
        .LEN_W     (COORD_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (min_len),
        .den   (maj_len),
        .done  (div_done),
        .quot  (div_quot)
    );

    gls_map_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W),
        .DATA_W (WORD_W)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (word_addr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLR;
            clr_cnt_reg    <= '0;
            blocked_reg    <= 1'b0;
            sx_reg         <= '0;
            sy_reg         <= '0;
            ex_reg         <= '0;
            ey_reg         <= '0;
            cx_reg         <= '0;
            cy_reg         <= '0;
            cv_reg         <= 1'b0;
            chk_reg        <= 1'b0;
            bit_sel_reg    <= '0;
            hit_reg        <= 1'b0;
            x_major_reg    <= 1'b0;
            maj_up_reg     <= 1'b0;
            min_up_reg     <= 1'b0;
            maj_pos_reg    <= '0;
            acc_reg        <= '0;
            inc_reg        <= '0;
            step_cnt_reg   <= '0;
            out_valid_reg  <= 1'b0;
            clear_path_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready && (state_reg != ST_DONE))
            begin
                out_valid_reg <= 1'b0;
            end

            // read pipeline: address stage then bit check
            bit_sel_reg <= cell_idx[WORD_BW-1:0];
            chk_reg     <= cv_reg && in_grid;
            if (chk_reg && ram_rdata[bit_sel_reg])
            begin
                hit_reg <= 1'b1;
            end
            cv_reg <= (state_reg == ST_WALK) && (step_cnt_reg != '0);

            unique case (state_reg)
                ST_CLR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
                    if (clr_cnt_reg == ADDR_W'(DEPTH - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        sx_reg      <= start_x;
                        sy_reg      <= start_y;
                        ex_reg      <= end_x;
                        ey_reg      <= end_y;
                        cx_reg      <= start_x;
                        cy_reg      <= start_y;
                        blocked_reg <= blocked;
                        state_reg   <= (action == ACT_QUERY) ? ST_SETUP : ST_WR_RD;
                    end
                end
                ST_WR_RD:
                begin
                    state_reg <= in_grid ? ST_WR_WB : ST_IDLE;
                end
                ST_WR_WB:
                begin
                    state_reg <= ST_IDLE;
                end
                ST_SETUP:
                begin
                    hit_reg      <= 1'b0;
                    x_major_reg  <= x_major;
                    maj_up_reg   <= x_major ? (ex_reg >= sx_reg) : (ey_reg >= sy_reg);
                    min_up_reg   <= x_major ? (ey_reg >= sy_reg) : (ex_reg >= sx_reg);
                    step_cnt_reg <= maj_len;
                    state_reg    <= zero_len ? ST_DONE : ST_DIV;
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        inc_reg     <= div_quot;
                        maj_pos_reg <= x_major_reg ? COORD_W'(sx_reg) : COORD_W'(sy_reg);
                        acc_reg     <= x_major_reg ? {COORD_W'(sy_reg), FRAC_BITS'(0)}
                                                   : {COORD_W'(sx_reg), FRAC_BITS'(0)};
                        state_reg   <= ST_WALK;
                    end
                end
                ST_WALK:
                begin
                    if (step_cnt_reg != '0)
                    begin
                        maj_pos_reg  <= maj_next;
                        acc_reg      <= acc_next;
                        cx_reg       <= cx_next;
                        cy_reg       <= cy_next;
                        step_cnt_reg <= step_cnt_reg - COORD_W'(1);
                    end
                    else if (!cv_reg && !chk_reg)
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg  <= 1'b1;
                        clear_path_reg <= !hit_reg;
                        state_reg      <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign in_ready   = (state_reg == ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign clear_path = clear_path_reg;

endmodule

`default_nettype wire

### sim/tb_grid_line_of_sight.sv
// Self-checking testbench for grid_line_of_sight: wall writes and line-of-sight queries.
module tb_grid_line_of_sight;

    timeunit 1ns;
    timeprecision 1ps;

    import gls_pkg::*;

    localparam int GRID_W      = GRID_W_DEF;
    localparam int GRID_H      = GRID_H_DEF;
    localparam int FRAC        = FRAC_BITS_DEF;
    localparam int WIN         = 24;
    localparam int CYCLE_LIMIT = 4000000;

    typedef struct {
        logic             action;
        logic [X_W-1:0]   sx;
        logic [Y_W-1:0]   sy;
        logic [X_W-1:0]   ex;
        logic [Y_W-1:0]   ey;
        logic             blocked;
        bit               hold;
    } grid_word_t;

    logic           clk        = 1'b0;
    logic           rst_n      = 1'b0;
    logic           in_valid   = 1'b0;
    logic           in_ready;
    logic           action     = ACT_WRITE;
    logic [X_W-1:0] start_x    = '0;
    logic [Y_W-1:0] start_y    = '0;
    logic [X_W-1:0] end_x      = '0;
    logic [Y_W-1:0] end_y      = '0;
    logic           blocked    = 1'b0;
    logic           out_valid;
    logic           out_ready  = 1'b0;
    logic           clear_path;

    grid_word_t word_q[$];
    grid_word_t cur_word;
    bit         path_clear_q[$];
    bit         wall_map [0:GRID_W-1][0:GRID_H-1];
    bit         hold_next;

    int unsigned item_total;
    int unsigned sent_cnt;
    int unsigned write_cnt;
    int unsigned query_cnt;
    int unsigned shadowed_cnt;
    int unsigned mismatch_cnt;
    int unsigned cycle_cnt;

    grid_line_of_sight i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .action     (action),
        .start_x    (start_x),
        .start_y    (start_y),
        .end_x      (end_x),
        .end_y      (end_y),
        .blocked    (blocked),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .clear_path (clear_path)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // DDA walk over the shadow map: minor axis in fixed point, end cell forced
    function automatic bit walk_is_clear(input int sx, input int sy, input int ex, input int ey);
        int     adx, ady, maj_len, min_len, maj_pos, cx, cy;
        longint min_acc, inc;
        bit     x_major, maj_up, min_up;
        adx = (ex >= sx) ? ex - sx : sx - ex;
        ady = (ey >= sy) ? ey - sy : sy - ey;
        if (adx == 0 && ady == 0)
            return 1'b1;
        x_major = (ady <= adx);
        maj_len = x_major ? adx : ady;
        min_len = x_major ? ady : adx;
        maj_up  = x_major ? (ex >= sx) : (ey >= sy);
        min_up  = x_major ? (ey >= sy) : (ex >= sx);
        maj_pos = x_major ? sx : sy;
        min_acc = longint'(x_major ? sy : sx) << FRAC;
        inc     = (longint'(min_len) << FRAC) / maj_len;
        for (int k = 1; k <= maj_len; k++)
        begin
            maj_pos = maj_up ? maj_pos + 1 : maj_pos - 1;
            min_acc = min_up ? min_acc + inc : min_acc - inc;
            if (k == maj_len)
            begin
                cx = ex;
                cy = ey;
            end
            else if (x_major)
            begin
                cx = maj_pos;
                cy = int'(min_acc >> FRAC);
            end
            else
            begin
                cx = int'(min_acc >> FRAC);
                cy = maj_pos;
            end
            if (wall_map[cx][cy])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic int pace_phase();
        if (item_total == 0)
            return 0;
        return (sent_cnt * 4) / item_total;
    endfunction

    function automatic int send_gap_pct();
        case (pace_phase())
            1:       return 52;
            3:       return 21;
            default: return 0;
        endcase
    endfunction

    function automatic int stall_pct();
        case (pace_phase())
            2:       return 52;
            3:       return 21;
            default: return 0;
        endcase
    endfunction

    function automatic void push_write(input int x, input int y, input bit b);
        grid_word_t w;
        w.action  = ACT_WRITE;
        w.sx      = X_W'(x);
        w.sy      = Y_W'(y);
        w.ex      = X_W'($urandom_range(GRID_W - 1));
        w.ey      = Y_W'($urandom_range(GRID_H - 1));
        w.blocked = b;
        w.hold    = hold_next;
        hold_next = 1'b0;
        word_q.push_back(w);
    endfunction

    function automatic void push_query(input int sx, input int sy, input int ex, input int ey);
        grid_word_t w;
        w.action  = ACT_QUERY;
        w.sx      = X_W'(sx);
        w.sy      = Y_W'(sy);
        w.ex      = X_W'(ex);
        w.ey      = Y_W'(ey);
        w.blocked = 1'($urandom_range(1));
        w.hold    = hold_next;
        hold_next = 1'b0;
        word_q.push_back(w);
    endfunction

    // driver: shadow map and expectations updated on acceptance
    always @(posedge clk or negedge rst_n)
    begin
        bit go;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                if (cur_word.action == ACT_QUERY)
                begin
                    path_clear_q.push_back(walk_is_clear(cur_word.sx, cur_word.sy,
                                                         cur_word.ex, cur_word.ey));
                    query_cnt++;
                end
                else
                begin
                    wall_map[cur_word.sx][cur_word.sy] = cur_word.blocked;
                    write_cnt++;
                end
                sent_cnt++;
            end
            if (!in_valid || in_ready)
            begin
                go = (word_q.size() > 0) && ($urandom_range(99) >= send_gap_pct());
                if (go && word_q[0].hold && path_clear_q.size() > 0)
                    go = 1'b0;
                if (go)
                begin
                    cur_word = word_q.pop_front();
                    action   <= cur_word.action;
                    start_x  <= cur_word.sx;
                    start_y  <= cur_word.sy;
                    end_x    <= cur_word.ex;
                    end_y    <= cur_word.ey;
                    blocked  <= cur_word.blocked;
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        bit want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (path_clear_q.size() == 0)
                begin
                    $error("clear_path: unexpected word, got %0b", clear_path);
                    mismatch_cnt++;
                end
                else
                begin
                    want = path_clear_q.pop_front();
                    if (!want)
                        shadowed_cnt++;
                    if (clear_path !== want)
                    begin
                        $error("clear_path: expected %0b, got %0b", want, clear_path);
                        mismatch_cnt++;
                    end
                end
            end
            out_ready <= ($urandom_range(99) >= stall_pct());
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        int wx, wy, r, ax, ay, bx, by;

        // directed
        push_query(0, 0, GRID_W - 1, GRID_H - 1);
        push_write(GRID_W - 1, GRID_H - 1, 1'b1);
        push_query(0, 0, GRID_W - 1, GRID_H - 1);
        push_query(GRID_W - 1, GRID_H - 1, GRID_W - 1, GRID_H - 1);
        push_write(0, 0, 1'b1);
        push_query(0, 0, 5, 0);
        push_query(5, 0, 0, 0);
        push_write(0, 256, 1'b1);
        push_query(0, 0, 0, GRID_H - 1);
        push_query(0, GRID_H - 1, 0, 300);
        push_write(10, 3, 1'b1);
        push_query(0, 0, 30, 9);
        push_query(30, 9, 0, 0);
        push_query(20, 20, 0, 14);
        push_query(2, 40, 9, 0);
        push_query(12, 0, 8, 30);
        push_write(GRID_W - 1, 0, 1'b1);
        push_write(0, GRID_H - 1, 1'b1);
        push_query(GRID_W - 1, GRID_H - 1, 0, GRID_H - 1);
        push_query(GRID_W - 1, 0, GRID_W - 1, GRID_H - 1);
        push_write(GRID_W - 1, GRID_H - 1, 1'b0);
        push_query(0, 0, GRID_W - 1, GRID_H - 1);
        push_query(GRID_W - 1, 0, 0, GRID_H - 1);

        // random: mostly dense activity inside a small moving window
        wx = 0;
        wy = 0;
        for (int i = 0; i < 400; i++)
        begin
            if (i % 90 == 0)
            begin
                r  = $urandom_range(3);
                wx = (r == 0) ? 0 : (r == 1) ? GRID_W - WIN : $urandom_range(GRID_W - WIN);
                wy = (r == 0) ? 0 : (r == 1) ? GRID_H - WIN : $urandom_range(GRID_H - WIN);
            end
            if (i == 180 || i == 360)
                hold_next = 1'b1;
            ax = wx + $urandom_range(WIN - 1);
            ay = wy + $urandom_range(WIN - 1);
            bx = wx + $urandom_range(WIN - 1);
            by = wy + $urandom_range(WIN - 1);
            r  = $urandom_range(99);
            if (r < 35)
                push_write(ax, ay, $urandom_range(9) < 7);
            else if (r < 75)
                push_query(ax, ay, bx, by);
            else if (r < 85)
                push_query($urandom_range(GRID_W - 1), $urandom_range(GRID_H - 1),
                           $urandom_range(GRID_W - 1), $urandom_range(GRID_H - 1));
            else if (r < 93)
            begin
                push_write(bx, by, 1'b1);
                push_query(ax, ay, bx, by);
            end
            else
            begin
                push_write(bx, by, 1'b1);
                push_write(bx, by, 1'b0);
                push_write(ax, ay, 1'b1);
                push_query(ax, ay, bx, by);
            end
        end
        item_total = word_q.size();

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (word_q.size() > 0 || in_valid)
            @(posedge clk);
        while (path_clear_q.size() > 0)
            @(posedge clk);
        repeat (1200) @(posedge clk);

        $display("covered %0d cell writes and %0d line queries (%0d answered blocked)",
                 write_cnt, query_cnt, shadowed_cnt);
        $display("under free-running, sender-gap, receiver-stall and mixed pacing");
        if (mismatch_cnt == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
